@@ hw/rtl/pidtm_pkg.sv @@
// ----------------------------------------------------------------------------
// PID controller, two modes: shared package
// Register map, field widths and the configuration bundle used by the
// register file, the datapath and the top level.
// ----------------------------------------------------------------------------
package pidtm_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   localparam int GAIN_W     = 21;
   localparam int ILIM_W     = 20;
   localparam int OLIM_W     = 15;
   localparam int DRIVE_W    = 16;
   localparam int ERR_SUM_W  = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   localparam logic [CSR_IDX_W-1:0] REG_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic [ILIM_W-1:0]        integral_limit;
      logic [OLIM_W-1:0]        output_limit;
   } cfg_type;

endpackage

@@ hw/rtl/pidtm_csr.sv @@
// ----------------------------------------------------------------------------
// PID controller, two modes: configuration registers
// Holds the mode, the three gains and the two limits, written through a
// plain write port. Writes to unused indices are dropped.
// ----------------------------------------------------------------------------
module pidtm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [pidtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pidtm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pidtm_pkg::cfg_type                cfg
);

   pidtm_pkg::cfg_type cfg_ff;
   pidtm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pidtm_pkg::REG_MODE: begin
               cfg_in.mode = csr_wdata[0];
            end
            pidtm_pkg::REG_GAIN_P: begin
               cfg_in.gain_p = $signed(csr_wdata[pidtm_pkg::GAIN_W-1:0]);
            end
            pidtm_pkg::REG_GAIN_I: begin
               cfg_in.gain_i = $signed(csr_wdata[pidtm_pkg::GAIN_W-1:0]);
            end
            pidtm_pkg::REG_GAIN_D: begin
               cfg_in.gain_d = $signed(csr_wdata[pidtm_pkg::GAIN_W-1:0]);
            end
            pidtm_pkg::REG_INTEGRAL_LIMIT: begin
               cfg_in.integral_limit = csr_wdata[pidtm_pkg::ILIM_W-1:0];
            end
            pidtm_pkg::REG_OUTPUT_LIMIT: begin
               cfg_in.output_limit = csr_wdata[pidtm_pkg::OLIM_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/pidtm_datapath.sv @@
// ----------------------------------------------------------------------------
// PID controller, two modes: datapath
// Forms the error, the clamped error sum and the three gain products, and
// from them the clamped drive value for either positional or incremental
// operation.
// ----------------------------------------------------------------------------
module pidtm_datapath #(
   parameter int SAMPLE_WIDTH   = pidtm_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pidtm_pkg::GAIN_FRAC_BITS_DEF
) (
   input  pidtm_pkg::cfg_type                          cfg,
   input  logic signed [SAMPLE_WIDTH-1:0]              setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]              feedback,
   input  logic signed [SAMPLE_WIDTH:0]                err_prev,
   input  logic signed [SAMPLE_WIDTH:0]                err_prev2,
   input  logic signed [pidtm_pkg::ERR_SUM_W-1:0]      err_sum,
   input  logic signed [pidtm_pkg::DRIVE_W-1:0]        out_prev,
   output logic signed [SAMPLE_WIDTH:0]                err,
   output logic signed [pidtm_pkg::ERR_SUM_W-1:0]      err_sum_next,
   output logic signed [pidtm_pkg::DRIVE_W-1:0]        drive
);

   localparam int EW   = SAMPLE_WIDTH + 1;
   localparam int DW   = SAMPLE_WIDTH + 3;
   localparam int SW   = pidtm_pkg::ERR_SUM_W;
   localparam int GW   = pidtm_pkg::GAIN_W;
   localparam int IW   = (EW > SW) ? EW : SW;
   localparam int AW   = ((DW > SW) ? DW : SW) + GW + 3;

   logic signed [EW-1:0]      e;
   logic signed [AW-1:0]      e_w;
   logic signed [AW-1:0]      e1_w;
   logic signed [AW-1:0]      e2_w;
   logic signed [AW-1:0]      d1_w;
   logic signed [AW-1:0]      d2_w;
   logic signed [AW-1:0]      il_w;
   logic signed [AW-1:0]      il_q_w;
   logic signed [AW-1:0]      ol_w;
   logic signed [AW-1:0]      sum_raw;
   logic signed [AW-1:0]      sum_cl;
   logic signed [EW:0]        op_p;
   logic signed [IW-1:0]      op_i;
   logic signed [EW+1:0]      op_d;
   logic signed [GW+EW:0]     prod_p;
   logic signed [GW+IW-1:0]   prod_i;
   logic signed [GW+EW+1:0]   prod_d;
   logic signed [AW-1:0]      term_i;
   logic signed [AW-1:0]      acc;
   logic signed [AW-1:0]      base;
   logic signed [AW-1:0]      drv_raw;
   logic signed [AW-1:0]      drv_cl;
   logic                      incremental;

   assign incremental = (cfg.mode == pidtm_pkg::MODE_INCREMENTAL);

   assign e    = EW'(setpoint) - EW'(feedback);
   assign e_w  = AW'(e);
   assign e1_w = AW'(err_prev);
   assign e2_w = AW'(err_prev2);
   assign d1_w = e_w - e1_w;
   assign d2_w = e_w - (e1_w <<< 1) + e2_w;

   assign il_w   = AW'($signed({1'b0, cfg.integral_limit}));
   assign il_q_w = il_w <<< GAIN_FRAC_BITS;
   assign ol_w   = AW'($signed({1'b0, cfg.output_limit}));

   assign sum_raw = AW'(err_sum) + e_w;

   always_comb begin
      if (sum_raw > il_w) begin
         sum_cl = il_w;
      end else if (sum_raw < -il_w) begin
         sum_cl = -il_w;
      end else begin
         sum_cl = sum_raw;
      end
   end

   assign op_p = incremental ? d1_w[EW:0] : (EW+1)'(e);
   assign op_i = incremental ? IW'(e) : sum_cl[IW-1:0];
   assign op_d = incremental ? d2_w[EW+1:0] : d1_w[EW+1:0];

   assign prod_p = cfg.gain_p * op_p;
   assign prod_i = cfg.gain_i * op_i;
   assign prod_d = cfg.gain_d * op_d;

   always_comb begin
      term_i = AW'(prod_i);
      if (incremental) begin
         if (AW'(prod_i) > il_q_w) begin
            term_i = il_q_w;
         end else if (AW'(prod_i) < -il_q_w) begin
            term_i = -il_q_w;
         end
      end
   end

   assign acc     = AW'(prod_p) + term_i + AW'(prod_d);
   assign base    = incremental ? AW'(out_prev) : '0;
   assign drv_raw = base + (acc >>> GAIN_FRAC_BITS);

   always_comb begin
      if (drv_raw > ol_w) begin
         drv_cl = ol_w;
      end else if (drv_raw < -ol_w) begin
         drv_cl = -ol_w;
      end else begin
         drv_cl = drv_raw;
      end
   end

   assign err          = e;
   assign err_sum_next = sum_cl[SW-1:0];
   assign drive        = drv_cl[pidtm_pkg::DRIVE_W-1:0];

endmodule

@@ hw/rtl/pid_controller_two_mode_core.sv @@
// ----------------------------------------------------------------------------
// PID controller, two modes: top level
// Each request carries a setpoint and a feedback sample; the response is one
// clamped drive value from a positional or an incremental PID law.
//
// Requests enter on req_valid/req_ready and are held in an input register.
// The datapath is combinational between that register and the response
// register, updating the error history, the error sum (positional mode
// only) and the previous output as the result is stored.
// The request is first held in the input register; once the response
// register is free, the result is stored there and rsp_valid rises.
// Throughput: one transfer per cycle while rsp_ready stays high, set by
// the datapath and its state update.
// When the receiver holds rsp_ready low, the response register keeps its
// value, the input register fills, and req_ready falls until the response
// is taken; nothing is lost or repeated.
// Reset clears the controller state, the configuration and both valid
// flags. Configuration is written through csr_wr_en, csr_index, csr_wdata
// while no sample is in flight; the user must ensure this, not the block.
// ----------------------------------------------------------------------------
module pid_controller_two_mode_core #(
   parameter int SAMPLE_WIDTH   = pidtm_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pidtm_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_feedback,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pidtm_pkg::DRIVE_W-1:0]   rsp_drive,
   input  logic                                   csr_wr_en,
   input  logic [pidtm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pidtm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   pidtm_pkg::cfg_type cfg;

   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]         sp_ff;
   logic signed [SAMPLE_WIDTH-1:0]         fb_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic signed [pidtm_pkg::DRIVE_W-1:0]   drive_ff;
   logic signed [SAMPLE_WIDTH:0]           err_prev_ff;
   logic signed [SAMPLE_WIDTH:0]           err_prev2_ff;
   logic signed [pidtm_pkg::ERR_SUM_W-1:0] err_sum_ff;
   logic signed [pidtm_pkg::ERR_SUM_W-1:0] err_sum_in;
   logic signed [pidtm_pkg::DRIVE_W-1:0]   out_prev_ff;
   logic signed [SAMPLE_WIDTH:0]           err;
   logic signed [pidtm_pkg::ERR_SUM_W-1:0] err_sum_next;
   logic signed [pidtm_pkg::DRIVE_W-1:0]   drive;
   logic                                   out_free;
   logic                                   advance;
   logic                                   req_xfer;

   pidtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidtm_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .cfg          (cfg),
      .setpoint     (sp_ff),
      .feedback     (fb_ff),
      .err_prev     (err_prev_ff),
      .err_prev2    (err_prev2_ff),
      .err_sum      (err_sum_ff),
      .out_prev     (out_prev_ff),
      .err          (err),
      .err_sum_next (err_sum_next),
      .drive        (drive)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign err_sum_in   = (cfg.mode == pidtm_pkg::MODE_POSITIONAL) ? err_sum_next : err_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         err_prev_ff  <= '0;
         err_prev2_ff <= '0;
         err_sum_ff   <= '0;
         out_prev_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            err_prev_ff  <= err;
            err_prev2_ff <= err_prev_ff;
            err_sum_ff   <= err_sum_in;
            out_prev_ff  <= drive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sp_ff <= req_setpoint;
         fb_ff <= req_feedback;
      end
      if (advance) begin
         drive_ff <= drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

endmodule
